@@ src/noise_shaped_audio_dither_core_assert.svh @@
// ----------------------------------------------------------------------------
// Noise-shaped audio dither core: assertion macros
// Concurrent check wrappers, clocked on clk and disabled during arst_n low.
// ----------------------------------------------------------------------------
`ifndef NOISE_SHAPED_AUDIO_DITHER_CORE_ASSERT_SVH
`define NOISE_SHAPED_AUDIO_DITHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NSAD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("noise_shaped_audio_dither_core: check failed");
// next-cycle implication
`define NSAD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("noise_shaped_audio_dither_core: check failed");
`else
`define NSAD_ASSERT_IMP(lbl, ante, cons)
`define NSAD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ src/nsad_pkg.sv @@
// ----------------------------------------------------------------------------
// nsad_pkg
// Shared types and constants of the noise-shaped audio dither core.
// ----------------------------------------------------------------------------
`default_nettype none

package nsad_pkg;

	localparam int MAX_CHANNELS = 9;
	localparam int FRAC_BITS    = 28;
	localparam int CHAN_W       = 4;
	localparam int SAMPLE_W     = 32;
	localparam int ACC_W        = 36;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 4;

	typedef logic signed [ACC_W-1:0] acc_t;

	localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ON     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

	localparam logic [SAMPLE_W-1:0] LCG_MUL = 32'h0019_660D;
	localparam logic [SAMPLE_W-1:0] LCG_ADD = 32'h3C6E_F35F;

	localparam acc_t ONE     = acc_t'(1) <<< FRAC_BITS;
	localparam acc_t NEG_ONE = -ONE;

	// target LSB exponents: 16-bit and 8-bit targets
	localparam int LSB16_EXP = FRAC_BITS - 15;
	localparam int LSB8_EXP  = FRAC_BITS - 7;
	localparam acc_t LSB16   = acc_t'(1) <<< LSB16_EXP;
	localparam acc_t LSB8    = acc_t'(1) <<< LSB8_EXP;
	// (diff * lsb) >> 32 is a plain right shift by these amounts
	localparam int DSH16     = SAMPLE_W - LSB16_EXP;
	localparam int DSH8      = SAMPLE_W - LSB8_EXP;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_ADD0 = 11'b000_0000_0010,
		ST_ADD1 = 11'b000_0000_0100,
		ST_ADD2 = 11'b000_0000_1000,
		ST_SEED = 11'b000_0001_0000,
		ST_DIFF = 11'b000_0010_0000,
		ST_Y0   = 11'b000_0100_0000,
		ST_Y1   = 11'b000_1000_0000,
		ST_CLIP = 11'b001_0000_0000,
		ST_ERR  = 11'b010_0000_0000,
		ST_DONE = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		acc_t a;
		acc_t b;
		logic sub;
	} alu_op_t;

endpackage

`default_nettype wire

@@ src/nsad_alu.sv @@
// ----------------------------------------------------------------------------
// nsad_alu
// Shared wide adder/subtractor, reused by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module nsad_alu (
	input  wire nsad_pkg::alu_op_t op,
	output nsad_pkg::acc_t         res
);
	import nsad_pkg::*;

	always_comb begin
		if (op.sub) begin
			res = op.a - op.b;
		end else begin
			res = op.a + op.b;
		end
	end

endmodule

`default_nettype wire

@@ src/noise_shaped_audio_dither_core.sv @@
// ----------------------------------------------------------------------------
// noise_shaped_audio_dither_core
// Noise-shaped linear dither with an LCG source for interleaved audio.
// ----------------------------------------------------------------------------
// Sequencing: a dithered item steps through the shared adder states ADD0 to ERR
//   before DONE, a bypassed item goes straight to DONE; an output stall holds DONE.
// The input stalls until the current item leaves DONE, so items never overlap;
//   this is set by the single shared adder stepping through its operations in turn.
// Reset: arst_n clears config to defaults, all taps, seeds and the channel
//   counter at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "noise_shaped_audio_dither_core_assert.svh"

module noise_shaped_audio_dither_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration write port
	input  wire                                 cfg_we,
	input  wire [nsad_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [nsad_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input channel
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire signed [nsad_pkg::SAMPLE_W-1:0] sample_in,
	input  wire                                 buffer_start,
	// output channel
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic signed [nsad_pkg::SAMPLE_W-1:0] sample_out
);
	import nsad_pkg::*;

	// configuration
	logic              dither_on_q;
	logic              tsel_q;
	logic [CHAN_W-1:0] ccount_q;

	// per-channel state, indexed by the item's channel
	logic [SAMPLE_W-1:0] err_now_q  [MAX_CHANNELS];
	logic [SAMPLE_W-1:0] err_prev_q [MAX_CHANNELS];
	logic [SAMPLE_W-1:0] err_old_q  [MAX_CHANNELS];
	logic [SAMPLE_W-1:0] seed_q     [MAX_CHANNELS];
	logic [CHAN_W-1:0]   chan_index_q;

	// sequencer and working registers
	state_t              state_q;
	logic [SAMPLE_W-1:0] x_q;
	logic [CHAN_W-1:0]   chan_q;
	acc_t                acc_q;
	acc_t                s_q;
	acc_t                y_q;
	acc_t                d_q;
	logic [SAMPLE_W-1:0] prod_q;
	logic [SAMPLE_W-1:0] n_q;
	logic [SAMPLE_W-1:0] res_q;

	// output register
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_q;

	logic                in_acc;
	logic                out_free;
	logic [CHAN_W-1:0]   count_w;
	logic [CHAN_W-1:0]   chan_w;
	logic [CHAN_W-1:0]   nxt_w;

	logic [SAMPLE_W-1:0] e0_rd;
	logic [SAMPLE_W-1:0] e1_rd;
	logic [SAMPLE_W-1:0] e2_rd;
	logic [SAMPLE_W-1:0] seed_rd;
	logic [SAMPLE_W-1:0] mul_lo;
	logic [SAMPLE_W-1:0] diff_w;
	acc_t                d_w;
	acc_t                y_clip;
	acc_t                s_clip;

	alu_op_t             alu_op;
	acc_t                alu_res;

	function automatic acc_t sext(input logic [SAMPLE_W-1:0] v);
		return {{(ACC_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
	endfunction

	function automatic acc_t zext(input logic [SAMPLE_W-1:0] v);
		return {{(ACC_W-SAMPLE_W){1'b0}}, v};
	endfunction

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign sample_out = out_q;
	assign out_free   = !out_valid_q || !out_stall;

	// channel select: clamp the count to [1, MAX_CHANNELS], restart on buffer start,
	// fall back to channel 0 when the counter lies beyond the count
	always_comb begin
		count_w = ccount_q;
		if (ccount_q == '0) begin
			count_w = CHAN_W'(1);
		end else if (ccount_q > CHAN_W'(MAX_CHANNELS)) begin
			count_w = CHAN_W'(MAX_CHANNELS);
		end
		chan_w = buffer_start ? '0 : chan_index_q;
		if (chan_w >= count_w) begin
			chan_w = '0;
		end
		nxt_w = chan_w + CHAN_W'(1);
		if (nxt_w >= count_w) begin
			nxt_w = '0;
		end
	end

	// state of the item's channel
	assign e0_rd   = err_now_q[chan_q];
	assign e1_rd   = err_prev_q[chan_q];
	assign e2_rd   = err_old_q[chan_q];
	assign seed_rd = seed_q[chan_q];

	// LCG multiply, low 32 bits only; registered before the add
	assign mul_lo = seed_rd * LCG_MUL;

	// seed step difference scaled by one target LSB is a right shift
	assign diff_w = alu_res[SAMPLE_W-1:0];
	assign d_w    = tsel_q ? (zext(diff_w) >> DSH16) : (zext(diff_w) >> DSH8);

	// saturate y to +/-1.0; clamp s on the same side only
	always_comb begin
		y_clip = acc_q;
		s_clip = s_q;
		if (acc_q > ONE) begin
			y_clip = ONE;
			if (s_q > ONE) begin
				s_clip = ONE;
			end
		end else if (acc_q < NEG_ONE) begin
			y_clip = NEG_ONE;
			if (s_q < NEG_ONE) begin
				s_clip = NEG_ONE;
			end
		end
	end

	// operand select for the shared adder, one operation per state
	always_comb begin
		alu_op.a   = '0;
		alu_op.b   = '0;
		alu_op.sub = 1'b0;
		case (state_q)
			ST_ADD0: begin
				alu_op.a = sext(x_q);
				alu_op.b = sext(e0_rd);
			end
			ST_ADD1: begin
				alu_op.a   = acc_q;
				alu_op.b   = sext(e1_rd);
				alu_op.sub = 1'b1;
			end
			ST_ADD2: begin
				alu_op.a = acc_q;
				alu_op.b = sext(e2_rd);
			end
			ST_SEED: begin
				alu_op.a = zext(prod_q);
				alu_op.b = zext(LCG_ADD);
			end
			ST_DIFF: begin
				alu_op.a   = zext(n_q);
				alu_op.b   = zext(seed_rd);
				alu_op.sub = 1'b1;
			end
			ST_Y0: begin
				alu_op.a = s_q;
				alu_op.b = tsel_q ? LSB16 : LSB8;
			end
			ST_Y1: begin
				alu_op.a = acc_q;
				alu_op.b = d_q;
			end
			ST_ERR: begin
				alu_op.a   = s_q;
				alu_op.b   = y_q;
				alu_op.sub = 1'b1;
			end
			default: begin
				alu_op.a   = '0;
				alu_op.b   = '0;
				alu_op.sub = 1'b0;
			end
		endcase
	end

	nsad_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	// configuration registers; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dither_on_q <= 1'b0;
			tsel_q      <= 1'b1;
			ccount_q    <= CHAN_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DITHER_ON:     dither_on_q <= cfg_data[0];
				CFG_TARGET_WIDTH:  tsel_q      <= cfg_data[0];
				CFG_CHANNEL_COUNT: ccount_q    <= cfg_data[CHAN_W-1:0];
				default:           ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			chan_index_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// raise the output item as the result moves in, release it once taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						// advance the counter even in bypass to track the buffer
						chan_index_q <= nxt_w;
						state_q      <= dither_on_q ? ST_ADD0 : ST_DONE;
					end
				end
				ST_ADD0: state_q <= ST_ADD1;
				ST_ADD1: state_q <= ST_ADD2;
				ST_ADD2: state_q <= ST_SEED;
				ST_SEED: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_Y0;
				ST_Y0:   state_q <= ST_Y1;
				ST_Y1:   state_q <= ST_CLIP;
				ST_CLIP: state_q <= ST_ERR;
				ST_ERR:  state_q <= ST_DONE;
				ST_DONE: begin
					// hold the result until the output register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					x_q    <= sample_in;
					res_q  <= sample_in;
					chan_q <= chan_w;
				end
			end
			ST_ADD0: begin
				acc_q  <= alu_res;
				prod_q <= mul_lo;
			end
			ST_ADD1: acc_q <= alu_res;
			ST_ADD2: s_q   <= alu_res;
			ST_SEED: n_q   <= alu_res[SAMPLE_W-1:0];
			ST_DIFF: d_q   <= d_w;
			ST_Y0:   acc_q <= alu_res;
			ST_Y1:   acc_q <= alu_res;
			ST_CLIP: begin
				y_q <= y_clip;
				s_q <= s_clip;
			end
			ST_ERR:  res_q <= y_q[SAMPLE_W-1:0];
			ST_DONE: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	// per-channel taps and seeds: shift the taps and store the new error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				err_now_q[i]  <= '0;
				err_prev_q[i] <= '0;
				err_old_q[i]  <= '0;
				seed_q[i]     <= '0;
			end
		end else if (state_q == ST_ERR) begin
			err_old_q[chan_q]  <= e1_rd;
			err_prev_q[chan_q] <= {e0_rd[SAMPLE_W-1], e0_rd[SAMPLE_W-1:1]};
			err_now_q[chan_q]  <= alu_res[SAMPLE_W-1:0];
			seed_q[chan_q]     <= n_q;
		end
	end

	// checks
	`NSAD_ASSERT_IMP(a_chan_range, 1'b1, chan_index_q < CHAN_W'(MAX_CHANNELS))
	`NSAD_ASSERT_NXT(a_bypass_path, in_valid && !in_stall && !dither_on_q, state_q == ST_DONE)
	`NSAD_ASSERT_IMP(a_clip_range, state_q == ST_ERR, (y_q <= ONE) && (y_q >= NEG_ONE))
	`NSAD_ASSERT_NXT(a_done_release, (state_q == ST_DONE) && out_free, out_valid_q && (state_q == ST_IDLE))

endmodule

`default_nettype wire

@@ tb/tb_noise_shaped_audio_dither_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_noise_shaped_audio_dither_core
// Checks the noise-shaped dither core against a per-channel predictor of the
// shaping taps, LCG seeds and clipping. The sender works in random bursts,
// the receiver stalls on its own patterns, and config changes between phases.
// ----------------------------------------------------------------------------

// Expected-sample store with its own copy of the per-channel dither state.
class dither_scoreboard;
	bit                 dith_en;
	bit                 lsb_sel;
	logic [3:0]         chan_cnt;
	logic [3:0]         chan_idx;
	logic signed [31:0] err_now  [nsad_pkg::MAX_CHANNELS];
	logic signed [31:0] err_prev [nsad_pkg::MAX_CHANNELS];
	logic signed [31:0] err_old  [nsad_pkg::MAX_CHANNELS];
	logic [31:0]        lcg_seed [nsad_pkg::MAX_CHANNELS];
	logic [31:0]        sample_q [$];
	int                 n_errors;

	function new();
		dith_en  = 1'b0;
		lsb_sel  = 1'b1;
		chan_cnt = 4'd2;
		chan_idx = 4'd0;
		foreach (err_now[i]) begin
			err_now[i]  = '0;
			err_prev[i] = '0;
			err_old[i]  = '0;
			lcg_seed[i] = '0;
		end
		n_errors = 0;
	endfunction

	function void set_reg(logic [nsad_pkg::CFG_IDX_W-1:0] idx,
			logic [nsad_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			nsad_pkg::CFG_DITHER_ON:     dith_en  = data[0];
			nsad_pkg::CFG_TARGET_WIDTH:  lsb_sel  = data[0];
			nsad_pkg::CFG_CHANNEL_COUNT: chan_cnt = data[3:0];
			default: ;
		endcase
	endfunction

	// Advance the channel counter and predict the dithered sample.
	function void note_sample(logic signed [31:0] x, bit start);
		int unsigned cnt;
		int unsigned c;
		int unsigned nxt;
		longint      one_v;
		longint      lsb;
		longint      e0;
		longint      e1;
		longint      e2;
		longint      s;
		longint      y;
		longint      d;
		logic [31:0] old_seed;
		logic [31:0] new_seed;
		logic [31:0] diff;
		logic [63:0] prod;

		cnt = chan_cnt;
		if (cnt == 0)
			cnt = 1;
		if (cnt > nsad_pkg::MAX_CHANNELS)
			cnt = nsad_pkg::MAX_CHANNELS;
		c = start ? 0 : chan_idx;
		if (c >= cnt)
			c = 0;
		nxt = c + 1;
		if (nxt >= cnt)
			nxt = 0;
		chan_idx = 4'(nxt);

		if (!dith_en) begin
			sample_q.push_back(x);
			return;
		end

		one_v = longint'(1) << nsad_pkg::FRAC_BITS;
		lsb   = lsb_sel ? (one_v >> 15) : (one_v >> 7);
		e0    = err_now[c];
		e1    = err_prev[c];
		e2    = err_old[c];
		s     = longint'(x) + e0 - e1 + e2;

		old_seed = lcg_seed[c];
		new_seed = old_seed * nsad_pkg::LCG_MUL + nsad_pkg::LCG_ADD;
		diff     = new_seed - old_seed;
		prod     = {32'd0, diff} * 64'(lsb);
		d        = longint'(prod >> 32);

		err_old[c]  = err_prev[c];
		err_prev[c] = 32'(e0 >>> 1);
		lcg_seed[c] = new_seed;

		y = s + lsb + d;
		if (y > one_v) begin
			y = one_v;
			if (s > one_v)
				s = one_v;
		end else if (y < -one_v) begin
			y = -one_v;
			if (s < -one_v)
				s = -one_v;
		end
		err_now[c] = 32'(s - y);
		sample_q.push_back(32'(y));
	endfunction

	function void log_error(string what);
		n_errors++;
		if (n_errors <= 10)
			$display("%s", what);
	endfunction

	function void check_sample(logic [31:0] got);
		logic [31:0] want;
		if (sample_q.size() == 0) begin
			log_error($sformatf("unexpected sample_out %h at %0t", got, $realtime));
			return;
		end
		want = sample_q.pop_front();
		if (got !== want)
			log_error($sformatf("sample_out mismatch at %0t: expected %h, got %h",
				$realtime, want, got));
	endfunction

	function int pending();
		return sample_q.size();
	endfunction
endclass

module tb_noise_shaped_audio_dither_core;
	import nsad_pkg::*;

	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
	localparam int DRAIN_CYCLES   = 16;    // settle time after the last expected sample
	localparam int RANDOM_ITEMS   = 1230;

	// register index past the three defined ones; must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       buffer_start;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] sample_out;

	dither_scoreboard sb;
	bit               hold_req;
	int               burst_left;
	int               idle_run;

	always #2 clk = ~clk;

	noise_shaped_audio_dither_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.buffer_start (buffer_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out)
	);

	// Check every result the moment it is handed over.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_sample(sample_out);
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_run <= 0;
			else
				idle_run <= idle_run + 1;
			if (idle_run >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", idle_run);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Receiver: stall in segments of differing density; on request hold
	// off for a long stretch so the core backs up and stalls its input.
	initial begin
		int seg_len;
		int mode;
		int period;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
			mode    = $urandom_range(0, 3);
			seg_len = $urandom_range(10, 80);
			period  = $urandom_range(2, 7);
			for (int i = 0; i < seg_len; i++) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 0);
					2: out_stall <= ($urandom_range(0, 4) != 0);
					default: out_stall <= ((i % period) != 0);
				endcase
			end
		end
	end

	// Write one register; the write lands at the next rising edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Write all three registers; junk in the unused upper bits of the
	// one-bit registers must be dropped by the core.
	task automatic apply_setting(input bit en, input bit sel, input logic [3:0] cnt);
		write_reg(CFG_DITHER_ON, {3'($urandom), en});
		write_reg(CFG_TARGET_WIDTH, {3'($urandom), sel});
		write_reg(CFG_CHANNEL_COUNT, cnt);
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Offer one item and hold it until the core takes it.
	task automatic send_item(input logic signed [31:0] x, input bit start);
		@(negedge clk);
		in_valid     <= 1'b1;
		sample_in    <= x;
		buffer_start <= start;
		do @(posedge clk); while (in_stall);
		sb.note_sample(x, start);
	endtask

	// Send with burst-and-gap pacing; now and then a long unbroken burst.
	task automatic offer(input logic signed [31:0] x, input bit start);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 24);
			pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
		end
		burst_left--;
		send_item(x, start);
	endtask

	// Drop valid, wait for every expected sample, then let the core settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly in-range audio, with full-scale edges and raw 32-bit words.
	function automatic logic signed [31:0] rand_sample();
		case ($urandom_range(0, 9))
			0, 1: return 32'($urandom);
			2: return 32'((1 << FRAC_BITS) - 4096 + int'($urandom_range(0, 8192)));
			3: return 32'(-(1 << FRAC_BITS) - 4096 + int'($urandom_range(0, 8192)));
			4: return 32'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
			default: return 32'(int'($urandom_range(0, 1 << (FRAC_BITS + 1)))
				- (1 << FRAC_BITS));
		endcase
	endfunction

	initial begin
		int          n_rand;
		int          phase;
		int          phase_len;
		int          buf_len;
		int          k;
		int          cnt_eff;
		bit          en;
		bit          sel;
		logic [3:0]  cnt;

		sb           = new();
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		sample_in    = '0;
		buffer_start = 1'b0;
		hold_req     = 1'b0;
		burst_left   = 0;
		idle_run     = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: bypass, samples pass through untouched.
		send_item(32'sh7FFF_FFFF, 1'b1);
		send_item(32'sh8000_0000, 1'b0);
		drain();

		// 16-bit target, two channels: full scale and word extremes.
		apply_setting(1'b1, 1'b1, 4'd2);
		send_item(32'sh1000_0000, 1'b1);
		send_item(32'shF000_0000, 1'b0);
		send_item(32'sh7FFF_FFFF, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh0000_0000, 1'b0);
		drain();

		// 8-bit target: much larger bias and dither.
		apply_setting(1'b1, 1'b0, 4'd2);
		send_item(32'sh0FFF_0000, 1'b1);
		send_item(32'shF000_1234, 1'b0);
		drain();

		// Zero channels acts as one; above nine saturates to nine.
		apply_setting(1'b1, 1'b1, 4'd0);
		send_item(32'sh0123_4567, 1'b0);
		send_item(32'shFEDC_BA98, 1'b0);
		drain();
		apply_setting(1'b1, 1'b1, 4'd15);
		send_item(32'sh0800_0000, 1'b1);
		send_item(32'shF800_0000, 1'b0);
		drain();

		// Leave the counter at five, then drop the count below it.
		apply_setting(1'b1, 1'b1, 4'd9);
		send_item(32'sh0100_0000, 1'b1);
		send_item(32'sh0200_0000, 1'b0);
		send_item(32'sh0300_0000, 1'b0);
		send_item(32'sh0400_0000, 1'b0);
		send_item(32'sh0500_0000, 1'b0);
		drain();
		write_reg(CFG_CHANNEL_COUNT, 4'd3);
		send_item(32'sh0600_0000, 1'b0);
		send_item(32'sh0700_0000, 1'b0);
		drain();

		// Unused index is a no-op; bypass keeps taps and seeds intact.
		write_reg(CFG_UNUSED, 4'hF);
		write_reg(CFG_DITHER_ON, 4'd0);
		send_item(32'sh0ABC_DEF0, 1'b0);
		send_item(32'shF543_2110, 1'b0);
		drain();
		write_reg(CFG_DITHER_ON, 4'd1);
		send_item(32'sh0ABC_DEF0, 1'b0);
		send_item(32'shF543_2110, 1'b0);

		// Random phases: mostly whole buffers of frames, some broken ones.
		n_rand = 0;
		phase  = 0;
		while (n_rand < RANDOM_ITEMS) begin
			drain();
			case (phase)
				0: begin
					en = 1'b1; sel = 1'b0; cnt = 4'd9;
				end
				1: begin
					en = 1'b1; sel = 1'b1; cnt = 4'd1;
				end
				default: begin
					en  = ($urandom_range(0, 4) != 0);
					sel = $urandom_range(0, 1);
					cnt = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(1, 9));
				end
			endcase
			apply_setting(en, sel, cnt);
			cnt_eff = (cnt == 0) ? 1 : (cnt > MAX_CHANNELS) ? MAX_CHANNELS : cnt;

			// back up the core behind a long receiver hold-off now and then
			if (phase == 1 || phase % 7 == 3)
				hold_req = 1'b1;

			phase_len = $urandom_range(40, 120);
			k = 0;
			while (k < phase_len) begin
				if ($urandom_range(0, 7) == 0)
					buf_len = $urandom_range(1, 20);
				else
					buf_len = cnt_eff * $urandom_range(1, 8);
				for (int i = 0; i < buf_len && k < phase_len; i++) begin
					offer(rand_sample(), (i == 0) || ($urandom_range(0, 39) == 0));
					k++;
				end
			end
			n_rand += phase_len;
			phase++;
		end

		drain();
		if (sb.n_errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
